// File: design/tws_pkg.sv
// Package for the trie word store: sizes, command codes and node-table types.
package tws_pkg;

    // Node pool and alphabet size
    localparam int NODES    = 1024;
    localparam int ALPHABET = 26;

    // Widths that follow from the sizes
    localparam int NODE_W = $clog2(NODES);
    localparam int FREE_W = $clog2(NODES + 1);
    localparam int LIDX_W = $clog2(ALPHABET);
    localparam int ROW_W  = ALPHABET * NODE_W;

    // Item field widths
    localparam int CMD_W    = 2;
    localparam int LETTER_W = 5;

    // Command codes (the unused code acts as a prefix test)
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PREFIX = 2'd2;

    // Node index and one child row of the node table
    typedef logic [NODE_W-1:0] t_node;
    typedef t_node [ALPHABET-1:0] t_row;

endpackage

// File: design/tws_if.sv
// Stream interfaces for letter items in and word results out.
interface tws_in_if;
    logic                          valid;
    logic                          ready;
    logic [tws_pkg::CMD_W-1:0]     cmd;
    logic [tws_pkg::LETTER_W-1:0]  letter;
    logic                          no_letter;
    logic                          last;

    modport source (output valid, cmd, letter, no_letter, last, input ready);
    modport sink   (input valid, cmd, letter, no_letter, last, output ready);
endinterface

interface tws_out_if;
    logic valid;
    logic ready;
    logic found;
    logic full_res;

    modport source (output valid, found, full_res, input ready);
    modport sink   (input valid, found, full_res, output ready);
endinterface

// File: design/trie_word_store.sv
// Trie word store: insert, search and prefix test over a node table in RAM.
// Per item, S_IDLE accepts it and issues the row read, and S_PROC updates the
// row and, for a last item, issues the end-mark access; a last item then waits
// in S_END for a free output register. A new item is taken only in S_IDLE,
// after the child-row RAM read-modify-write. After reset both RAMs are swept
// to zero, one row a cycle, all NODES (1024) rows, with no item taken meanwhile.
module trie_word_store (
    input  logic            i_clk,
    input  logic            i_rst_n,
    tws_in_if.sink          i_in,
    tws_out_if.source       o_out
);

    // Controller states
    localparam logic [1:0] S_CLR  = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_PROC = 2'd2;
    localparam logic [1:0] S_END  = 2'd3;

    localparam logic [tws_pkg::LETTER_W:0] ALPHA_LIM =
        (tws_pkg::LETTER_W + 1)'(tws_pkg::ALPHABET);
    localparam logic [tws_pkg::FREE_W-1:0] FREE_LIM =
        tws_pkg::FREE_W'(tws_pkg::NODES);
    localparam logic [tws_pkg::NODE_W-1:0] CLR_LAST =
        tws_pkg::NODE_W'(tws_pkg::NODES - 1);

    logic [1:0]                        r_state, n_state;
    logic [tws_pkg::NODE_W-1:0]        r_clr_addr;
    logic [tws_pkg::FREE_W-1:0]        r_next_free;
    tws_pkg::t_node                    r_cur;
    logic                              r_broken;

    // Captured item
    logic [tws_pkg::CMD_W-1:0]         r_cmd;
    logic [tws_pkg::LETTER_W-1:0]      r_letter;
    logic                              r_no_letter;
    logic                              r_last;

    // Result being formed and output register
    logic                              r_pre_found;
    logic                              r_pre_full;
    logic                              r_use_mark;
    logic                              r_out_valid;
    logic                              r_out_found;
    logic                              r_out_full;

    // RAM ports
    logic                              row_we, row_re;
    tws_pkg::t_node                    row_waddr;
    tws_pkg::t_row                     row_wdata, row_rdata;
    logic                              end_we, end_re;
    tws_pkg::t_node                    end_addr;
    logic                              end_wdata;
    logic                              end_rdata;

    // Update-step decode
    logic                              accept, out_free;
    logic                              is_ins, is_srch;
    logic                              take, missing, alloc, brk_new;
    tws_pkg::t_node                    child, node_new;

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);

    assign is_ins  = (r_cmd == tws_pkg::CMD_INSERT);
    assign is_srch = (r_cmd == tws_pkg::CMD_SEARCH);

    // Walk one letter from the row just read
    always_comb begin
        child    = row_rdata[r_letter[tws_pkg::LIDX_W-1:0]];
        take     = !r_no_letter && ({1'b0, r_letter} < ALPHA_LIM) && !r_broken;
        missing  = (child == '0);
        alloc    = take && missing && is_ins && (r_next_free < FREE_LIM);
        brk_new  = r_broken || (take && missing && !alloc);
        if (!take) begin
            node_new = r_cur;
        end else if (missing) begin
            node_new = alloc ? r_next_free[tws_pkg::NODE_W-1:0] : r_cur;
        end else begin
            node_new = child;
        end
    end

    // Child-row RAM: read at accept, written on allocation or clear
    always_comb begin
        row_re    = accept;
        row_we    = 1'b0;
        row_waddr = r_cur;
        row_wdata = row_rdata;
        row_wdata[r_letter[tws_pkg::LIDX_W-1:0]] = r_next_free[tws_pkg::NODE_W-1:0];
        if (r_state == S_CLR) begin
            row_we    = 1'b1;
            row_waddr = r_clr_addr;
            row_wdata = '0;
        end else if (r_state == S_PROC) begin
            row_we = alloc;
        end
    end

    // End-mark RAM: set on insert end, read on search end, cleared after reset
    always_comb begin
        end_we    = 1'b0;
        end_re    = 1'b0;
        end_addr  = node_new;
        end_wdata = 1'b1;
        if (r_state == S_CLR) begin
            end_we    = 1'b1;
            end_addr  = r_clr_addr;
            end_wdata = 1'b0;
        end else if (r_state == S_PROC && r_last) begin
            end_we = is_ins && !brk_new;
            end_re = is_srch;
        end
    end

    tws_ram #(.WIDTH(tws_pkg::ROW_W), .DEPTH(tws_pkg::NODES)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_re    (row_re),
        .i_raddr (r_cur),
        .o_rdata (row_rdata)
    );

    tws_ram #(.WIDTH(1), .DEPTH(tws_pkg::NODES)) u_end_ram (
        .i_clk   (i_clk),
        .i_we    (end_we),
        .i_waddr (end_addr),
        .i_wdata (end_wdata),
        .i_re    (end_re),
        .i_raddr (end_addr),
        .o_rdata (end_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR:  if (r_clr_addr == CLR_LAST) n_state = S_IDLE;
            S_IDLE: if (accept) n_state = S_PROC;
            S_PROC: n_state = r_last ? S_END : S_IDLE;
            S_END:  if (out_free) n_state = S_IDLE;
            default: n_state = S_CLR;
        endcase
    end

    // Control and walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_next_free <= tws_pkg::FREE_W'(1);
            r_cur       <= '0;
            r_broken    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (r_state == S_PROC) begin
                if (alloc) begin
                    r_next_free <= r_next_free + 1'b1;
                end
                // End of word returns the walk to the root
                if (r_last) begin
                    r_cur    <= '0;
                    r_broken <= 1'b0;
                end else begin
                    r_cur    <= node_new;
                    r_broken <= brk_new;
                end
            end
            if (r_state == S_END && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item capture and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd       <= i_in.cmd;
            r_letter    <= i_in.letter;
            r_no_letter <= i_in.no_letter;
            r_last      <= i_in.last;
        end
        if (r_state == S_PROC) begin
            r_pre_found <= !brk_new;
            r_pre_full  <= is_ins && brk_new;
            r_use_mark  <= is_srch;
        end
        if (r_state == S_END && out_free) begin
            r_out_found <= r_pre_found && (!r_use_mark || end_rdata);
            r_out_full  <= r_pre_full;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.found    = r_out_found;
    assign o_out.full_res = r_out_full;

    // The walk only ever stands on an allocated node
    a_cur_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tws_pkg::FREE_W'(r_cur) < r_next_free))
        else $error("walk node not allocated");

    // Each allocation takes exactly the next free node
    a_alloc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROC && alloc) |=> (r_next_free == $past(r_next_free) + 1'b1))
        else $error("free counter did not advance on allocation");

    // A result appears only after the end-of-word step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_END))
        else $error("result raised outside end step");

endmodule

// File: design/tws_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: tb/trie_word_store_tb.sv
// Self-checking testbench for trie_word_store: directed word table, then random words.
module trie_word_store_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Unused command code, handled by the block as a prefix test
    localparam logic [tws_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

    localparam int MAX_LEN        = 16;
    localparam int KNOWN_CAP      = 256;
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int DIR_N          = 25;

    typedef struct packed {
        logic [tws_pkg::CMD_W-1:0]    cmd;
        logic [tws_pkg::LETTER_W-1:0] letter;
        logic                         no_letter;
        logic                         last;
    } t_letter_item;

    typedef struct packed {
        logic found;
        logic full_res;
    } t_word_result;

    typedef struct packed {
        logic [4:0]                                len;
        logic [MAX_LEN-1:0][tws_pkg::LETTER_W-1:0] lets;
    } t_word;

    // One directed row; typed rows carry a hand-written result for their last transfer
    typedef struct packed {
        logic [tws_pkg::CMD_W-1:0]    cmd;
        logic [tws_pkg::LETTER_W-1:0] letter;
        logic                         no_letter;
        logic                         last;
        logic                         typed;
        logic                         found;
        logic                         full_res;
    } t_dir_row;

    localparam t_dir_row DIR_TABLE [DIR_N] = '{
        // empty word on a fresh store: root unmarked, prefix always holds
        '{tws_pkg::CMD_SEARCH, 5'd0,  1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
        '{tws_pkg::CMD_PREFIX, 5'd31, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
        // lookups in an empty trie
        '{tws_pkg::CMD_SEARCH, 5'd0,  1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
        '{tws_pkg::CMD_PREFIX, 5'd25, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
        // insert the empty word, then find it
        '{tws_pkg::CMD_INSERT, 5'd17, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
        '{tws_pkg::CMD_SEARCH, 5'd0,  1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
        // insert "az" closed by an out-of-range letter
        '{tws_pkg::CMD_INSERT, 5'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{tws_pkg::CMD_INSERT, 5'd25, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{tws_pkg::CMD_INSERT, 5'd31, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{tws_pkg::CMD_SEARCH, 5'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{tws_pkg::CMD_SEARCH, 5'd25, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
        // "a" is only a prefix so far; spare code acts as prefix test
        '{tws_pkg::CMD_SEARCH, 5'd0,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{CMD_SPARE,           5'd0,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
        // missing path
        '{tws_pkg::CMD_PREFIX, 5'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{tws_pkg::CMD_PREFIX, 5'd1,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
        // out-of-range letter skipped inside a search
        '{tws_pkg::CMD_SEARCH, 5'd26, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{tws_pkg::CMD_SEARCH, 5'd0,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
        // broken walk from a prefix test, ended by an insert: flags full
        '{tws_pkg::CMD_PREFIX, 5'd16, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{tws_pkg::CMD_INSERT, 5'd1,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
        // lone out-of-range letter marks the root
        '{tws_pkg::CMD_INSERT, 5'd26, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
        // letterless item in the middle of a word
        '{tws_pkg::CMD_INSERT, 5'd3,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{tws_pkg::CMD_INSERT, 5'd0,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{tws_pkg::CMD_SEARCH, 5'd3,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{tws_pkg::CMD_SEARCH, 5'd0,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{CMD_SPARE,           5'd2,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0}
    };

    localparam logic [tws_pkg::CMD_W-1:0] CMD_CODES_Q [3] =
        '{tws_pkg::CMD_SEARCH, tws_pkg::CMD_PREFIX, CMD_SPARE};

    logic clk = 1'b0;
    logic rst_n;

    tws_in_if  letters_ch ();
    tws_out_if words_ch ();

    trie_word_store i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (letters_ch),
        .o_out   (words_ch)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Trie predictor state
    tws_pkg::t_node child_of [tws_pkg::NODES*tws_pkg::ALPHABET];
    bit             word_end [tws_pkg::NODES];
    int unsigned    next_free_node;
    tws_pkg::t_node walk_node;
    bit             walk_stopped;

    t_word_result word_results_due [$];
    t_word        known_words [$];

    int items_sent;
    int words_sent;
    int full_due;
    int mismatches;
    int results_seen;
    int found_seen;
    int full_seen;
    int holds_req;
    int send_idle_pct;
    int recv_idle_pct;
    int idle_cycles;

    task automatic trie_clear();
        foreach (child_of[n]) child_of[n] = '0;
        foreach (word_end[n]) word_end[n] = 1'b0;
        next_free_node = 1;
        walk_node      = '0;
        walk_stopped   = 1'b0;
    endtask

    // Advance the walk by one letter transfer; returns 1 when a word result is due
    function automatic bit trie_advance(input t_letter_item it, output t_word_result res);
        int unsigned    slot;
        tws_pkg::t_node child;
        bit             is_ins;
        is_ins = (it.cmd == tws_pkg::CMD_INSERT);
        res    = '0;
        if (!it.no_letter && it.letter < tws_pkg::ALPHABET && !walk_stopped) begin
            slot  = int'(walk_node) * tws_pkg::ALPHABET + int'(it.letter);
            child = child_of[slot];
            if (child == '0) begin
                if (is_ins && next_free_node < tws_pkg::NODES) begin
                    child          = tws_pkg::t_node'(next_free_node);
                    next_free_node = next_free_node + 1;
                    child_of[slot] = child;
                    walk_node      = child;
                end else begin
                    walk_stopped = 1'b1;
                end
            end else begin
                walk_node = child;
            end
        end
        if (!it.last) return 1'b0;
        if (is_ins) begin
            if (walk_stopped) begin
                res.full_res = 1'b1;
            end else begin
                word_end[walk_node] = 1'b1;
                res.found           = 1'b1;
            end
        end else if (it.cmd == tws_pkg::CMD_SEARCH) begin
            res.found = !walk_stopped && word_end[walk_node];
        end else begin
            res.found = !walk_stopped;
        end
        walk_node    = '0;
        walk_stopped = 1'b0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Offer one letter transfer after a random gap, then update the predictor on acceptance
    task automatic offer_letter(input t_letter_item it, input bit typed,
                                input t_word_result typed_res);
        t_word_result res;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            letters_ch.valid  <= 1'b0;
            letters_ch.letter <= tws_pkg::LETTER_W'($urandom);
            @(negedge clk);
        end
        letters_ch.valid     <= 1'b1;
        letters_ch.cmd       <= it.cmd;
        letters_ch.letter    <= it.letter;
        letters_ch.no_letter <= it.no_letter;
        letters_ch.last      <= it.last;
        do @(posedge clk); while (letters_ch.ready !== 1'b1);
        items_sent++;
        if (trie_advance(it, res)) begin
            if (res.full_res) full_due++;
            if (typed) res = typed_res;
            words_sent++;
            word_results_due.push_back(res);
        end
    endtask

    task automatic send_word(input logic [tws_pkg::CMD_W-1:0] cmd, input t_word w);
        t_letter_item it;
        if (w.len == 0) begin
            it = '{cmd, tws_pkg::LETTER_W'($urandom_range(0, 31)), 1'b1, 1'b1};
            offer_letter(it, 1'b0, '0);
        end else begin
            for (int i = 0; i < w.len; i++) begin
                it = '{cmd, w.lets[i], 1'b0, i == w.len - 1};
                offer_letter(it, 1'b0, '0);
            end
        end
    endtask

    function automatic t_word random_word(input int lo, input int hi);
        t_word w;
        w     = '0;
        w.len = 5'($urandom_range(lo, hi));
        for (int i = 0; i < w.len; i++)
            w.lets[i] = tws_pkg::LETTER_W'($urandom_range(0, tws_pkg::ALPHABET - 1));
        return w;
    endfunction

    // Random words: mostly well-formed inserts and lookups of stored words, some noise
    task automatic run_random(input int n_items, input int insert_pct, input int max_len,
                              input int min_full);
        int                        start;
        int                        pick;
        int                        r;
        int                        new_len;
        t_word                     w;
        t_letter_item              it;
        logic [tws_pkg::CMD_W-1:0] qcmd;
        start = items_sent;
        while (items_sent - start < n_items || full_due < min_full) begin
            pick = $urandom_range(0, 99);
            if (pick < insert_pct) begin
                if (known_words.size() != 0 && $urandom_range(0, 3) == 0) begin
                    // extend a stored word so the walk shares its path
                    w       = known_words[$urandom_range(0, known_words.size() - 1)];
                    new_len = $urandom_range(w.len, max_len);
                    for (int i = w.len; i < new_len; i++)
                        w.lets[i] = tws_pkg::LETTER_W'(
                            $urandom_range(0, tws_pkg::ALPHABET - 1));
                    w.len = 5'(new_len);
                end else begin
                    w = random_word(($urandom_range(0, 19) == 0) ? 0 : 2, max_len);
                end
                send_word(tws_pkg::CMD_INSERT, w);
                if (known_words.size() < KNOWN_CAP) known_words.push_back(w);
                else known_words[$urandom_range(0, KNOWN_CAP - 1)] = w;
            end else begin
                r = $urandom_range(0, 9);
                if (r <= 6 && known_words.size() != 0) begin
                    w = known_words[$urandom_range(0, known_words.size() - 1)];
                    if ($urandom_range(0, 2) == 0) begin
                        w.len = 5'($urandom_range(0, w.len));
                    end else if ($urandom_range(0, 4) == 0 && w.len < MAX_LEN) begin
                        w.lets[w.len] = tws_pkg::LETTER_W'(
                            $urandom_range(0, tws_pkg::ALPHABET - 1));
                        w.len         = w.len + 5'd1;
                    end
                    qcmd = (r <= 3) ? tws_pkg::CMD_SEARCH :
                           ((r == 6) ? CMD_SPARE : tws_pkg::CMD_PREFIX);
                    send_word(qcmd, w);
                end else if (r <= 7) begin
                    qcmd = CMD_CODES_Q[$urandom_range(0, 2)];
                    send_word(qcmd, random_word(0, max_len));
                end else begin
                    // noise: per-transfer commands, wide letters, stray letterless items
                    new_len = $urandom_range(1, 6);
                    for (int i = 0; i < new_len; i++) begin
                        it.cmd       = tws_pkg::CMD_W'($urandom_range(0, 3));
                        it.letter    = tws_pkg::LETTER_W'($urandom_range(0, 31));
                        it.no_letter = ($urandom_range(0, 6) == 0);
                        it.last      = (i == new_len - 1);
                        offer_letter(it, 1'b0, '0);
                    end
                end
            end
        end
    endtask

    // Hold the sender until all pending word results are back
    task automatic settle_results();
        @(negedge clk);
        letters_ch.valid <= 1'b0;
        while (word_results_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Result side: random back-pressure plus requested long holds
    initial begin : result_ready
        int hold_left;
        int holds_done;
        hold_left  = 0;
        holds_done = 0;
        words_ch.ready <= 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                words_ch.ready <= 1'b0;
                hold_left--;
            end else if (holds_done < holds_req) begin
                holds_done++;
                hold_left = LONG_HOLD - 1;
                words_ch.ready <= 1'b0;
            end else begin
                words_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Compare each accepted word result with the oldest prediction
    always @(posedge clk) begin : check_words
        t_word_result want;
        if (words_ch.valid === 1'b1 && words_ch.ready === 1'b1) begin
            results_seen++;
            if (words_ch.found === 1'b1) found_seen++;
            if (words_ch.full_res === 1'b1) full_seen++;
            if (word_results_due.size() == 0) begin
                report_mismatch($sformatf("word result with none pending (found=%b full=%b)",
                                          words_ch.found, words_ch.full_res));
            end else begin
                want = word_results_due.pop_front();
                if (words_ch.found !== want.found)
                    report_mismatch($sformatf("result %0d: found=%b, predicted %b",
                                              results_seen, words_ch.found, want.found));
                if (words_ch.full_res !== want.full_res)
                    report_mismatch($sformatf("result %0d: full_res=%b, predicted %b",
                                              results_seen, words_ch.full_res, want.full_res));
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk) begin
        if ((letters_ch.valid === 1'b1 && letters_ch.ready === 1'b1) ||
            (words_ch.valid === 1'b1 && words_ch.ready === 1'b1)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("trie_word_store regression: fail");
                $finish;
            end
        end
    end

    // Main sequence
    initial begin
        t_letter_item it;
        t_word_result typed_res;
        rst_n                <= 1'b0;
        letters_ch.valid     <= 1'b0;
        letters_ch.cmd       <= tws_pkg::CMD_INSERT;
        letters_ch.letter    <= '0;
        letters_ch.no_letter <= 1'b0;
        letters_ch.last      <= 1'b0;
        items_sent    = 0;
        words_sent    = 0;
        full_due      = 0;
        mismatches    = 0;
        results_seen  = 0;
        found_seen    = 0;
        full_seen     = 0;
        holds_req     = 0;
        idle_cycles   = 0;
        send_idle_pct = 19;
        recv_idle_pct = 55;
        trie_clear();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int n = 0; n < DIR_N; n++) begin
            it        = '{DIR_TABLE[n].cmd, DIR_TABLE[n].letter,
                          DIR_TABLE[n].no_letter, DIR_TABLE[n].last};
            typed_res = '{DIR_TABLE[n].found, DIR_TABLE[n].full_res};
            offer_letter(it, DIR_TABLE[n].typed, typed_res);
        end
        settle_results();

        // sender idles lightly, result side heavily; one long result stall mid-way
        run_random(150, 45, 14, 0);
        holds_req++;
        run_random(150, 45, 14, 0);
        settle_results();

        // swapped idling, with a full drain in the middle
        send_idle_pct = 55;
        recv_idle_pct = 19;
        run_random(150, 45, 14, 0);
        settle_results();
        run_random(150, 45, 14, 0);
        settle_results();

        // no idling, insert-heavy until at least 20 full results are due
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(300, 75, MAX_LEN, 20);
        settle_results();

        $display("covered %0d words over %0d letter transfers; %0d results (%0d found, %0d full)",
                 words_sent, items_sent, results_seen, found_seen, full_seen);
        $display("trie grew to %0d of %0d nodes; %0d mismatches", next_free_node,
                 tws_pkg::NODES, mismatches);
        if (mismatches == 0) begin
            $display("trie_word_store regression: pass");
        end else begin
            $display("trie_word_store regression: fail");
        end
        $finish;
    end

endmodule

// File: files.f
design/tws_pkg.sv
design/tws_if.sv
design/tws_ram.sv
design/trie_word_store.sv
tb/trie_word_store_tb.sv
